### rtl/psk_hd_pkg.sv
// ----------------------------------------------------------------------------
// PSK hard demapper package
// Shared constants, register index codes, control structures and the CORDIC
// arctangent table used by the demapper modules.
// ----------------------------------------------------------------------------
package psk_hd_pkg;

    localparam int C_SAMPLE_BITS  = 16;
    localparam int C_PHASE_BITS   = 16;
    localparam int C_CORDIC_STEPS = 30;
    localparam int C_PRESCALE     = 32;
    localparam int C_ANGLE_FRAC   = 32;
    localparam int C_ANGLE_W      = C_ANGLE_FRAC + 2;
    localparam int C_ORDER_W      = 9;
    localparam int C_OFFSET_W     = 16;
    localparam int C_SYMBOL_W     = 8;
    localparam int C_MAX_ORDER    = 256;
    localparam int C_MIN_ORDER    = 2;
    localparam int C_ORDER_RESET  = 4;
    localparam int C_CFG_INDEX_W  = 2;
    localparam int C_CFG_DATA_W   = 16;

    localparam logic signed [C_ANGLE_W-1:0] C_HALF_TURN = C_ANGLE_W'(1) << (C_ANGLE_FRAC - 1);

    typedef enum logic [C_CFG_INDEX_W-1:0] {
        CFG_ORDER        = 2'd0,
        CFG_PHASE_OFFSET = 2'd1,
        CFG_BINARY_ORDER = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic vld;
        logic zero;
    } t_ctl;

    typedef struct packed {
        logic [C_ORDER_W-1:0]  order;
        logic [C_OFFSET_W-1:0] phase_offset;
        logic                  binary_order;
    } t_cfg;

    localparam logic [31:0] C_ATAN_TURNS [C_CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

endpackage

### rtl/psk_hd_cordic_cell.sv
// ----------------------------------------------------------------------------
// PSK hard demapper CORDIC cell
// One vectoring micro-rotation of the angle chain, registered, advancing with
// the shared pipeline enable.
// ----------------------------------------------------------------------------
module psk_hd_cordic_cell #(
    parameter int STEP = 0,
    parameter int XY_W = 50
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  psk_hd_pkg::t_ctl                       i_ctl,
    input  logic signed [XY_W-1:0]                 i_x,
    input  logic signed [XY_W-1:0]                 i_y,
    input  logic signed [psk_hd_pkg::C_ANGLE_W-1:0] i_z,
    output psk_hd_pkg::t_ctl                       o_ctl,
    output logic signed [XY_W-1:0]                 o_x,
    output logic signed [XY_W-1:0]                 o_y,
    output logic signed [psk_hd_pkg::C_ANGLE_W-1:0] o_z
);
    import psk_hd_pkg::*;

    localparam logic signed [C_ANGLE_W-1:0] ATAN = C_ANGLE_W'(C_ATAN_TURNS[STEP]);

    t_ctl                        r_ctl;
    logic signed [XY_W-1:0]      r_x;
    logic signed [XY_W-1:0]      r_y;
    logic signed [C_ANGLE_W-1:0] r_z;
    logic signed [XY_W-1:0]      n_x;
    logic signed [XY_W-1:0]      n_y;
    logic signed [C_ANGLE_W-1:0] n_z;
    logic signed [XY_W-1:0]      w_dx;
    logic signed [XY_W-1:0]      w_dy;

    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;

    always_comb begin
        if (!i_y[XY_W-1]) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

### rtl/psk_hd_slicer.sv
// ----------------------------------------------------------------------------
// PSK hard demapper slicer
// Rounds the CORDIC angle, removes the phase offset, scales by the order,
// rounds to the nearest phase index and maps it to a Gray or binary symbol.
// ----------------------------------------------------------------------------
module psk_hd_slicer #(
    parameter int PHASE_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  psk_hd_pkg::t_ctl                        i_ctl,
    input  logic signed [psk_hd_pkg::C_ANGLE_W-1:0] i_z,
    input  psk_hd_pkg::t_cfg                        i_cfg,
    output logic                                    o_vld,
    output logic [psk_hd_pkg::C_SYMBOL_W-1:0]       o_symbol
);
    import psk_hd_pkg::*;

    localparam int AW     = C_ANGLE_W - C_ANGLE_FRAC + PHASE_BITS;
    localparam int OW     = PHASE_BITS + 1;
    localparam int DW     = PHASE_BITS + 3;
    localparam int TW     = DW + C_ORDER_W + 1;
    localparam int RW     = TW - PHASE_BITS;
    localparam int STAGES = 7;

    localparam logic signed [C_ANGLE_W-1:0] HALF_Z =
        C_ANGLE_W'(1) << (C_ANGLE_FRAC - 1 - PHASE_BITS);
    localparam logic [TW-1:0] HALF_T = TW'(1) << (PHASE_BITS - 1);

    function automatic logic [C_ORDER_W-1:0] gray_to_bin(input logic [C_ORDER_W-1:0] g);
        logic [C_ORDER_W-1:0] b;
        for (int i = 0; i < C_ORDER_W; i++) begin
            b[i] = ^(g >> i);
        end
        return b;
    endfunction

    logic [STAGES-1:0]           r_vld;
    logic signed [C_ANGLE_W-1:0] w_z_sum;
    logic [OW-1:0]               w_off;
    logic [AW-1:0]               r_a;
    logic [AW-1:0]               n_a;
    logic [DW-1:0]               r_d;
    logic [DW-1:0]               n_d;
    logic signed [TW-1:0]        r_t;
    logic signed [TW-1:0]        n_t;
    logic [TW-1:0]               w_mag;
    logic [RW-1:0]               r_r;
    logic                        r_neg;
    logic [RW-1:0]               w_m;
    logic [RW-1:0]               w_two_m;
    logic [RW-1:0]               r_q2;
    logic [RW-1:0]               n_q2;
    logic [RW-1:0]               w_k_full;
    logic [C_ORDER_W-1:0]        r_k;
    logic [C_ORDER_W-1:0]        w_g;
    logic [C_ORDER_W-1:0]        n_sym;
    logic [C_SYMBOL_W-1:0]       r_sym;

    generate
        if (PHASE_BITS >= C_OFFSET_W) begin : g_off_shift
            assign w_off = OW'(i_cfg.phase_offset) << (PHASE_BITS - C_OFFSET_W);
        end else begin : g_off_round
            logic [C_OFFSET_W:0] w_off_sum;
            assign w_off_sum = {1'b0, i_cfg.phase_offset}
                             + ((C_OFFSET_W + 1)'(1) << (C_OFFSET_W - 1 - PHASE_BITS));
            assign w_off = OW'(w_off_sum >> (C_OFFSET_W - PHASE_BITS));
        end
    endgenerate

    assign w_z_sum = i_z + HALF_Z;
    assign n_a     = i_ctl.zero ? '0 : w_z_sum[C_ANGLE_W-1:C_ANGLE_FRAC-PHASE_BITS];
    assign n_d     = {r_a[AW-1], r_a} - {2'b00, w_off};
    assign n_t     = $signed(r_d) * $signed({1'b0, i_cfg.order});
    assign w_mag   = r_t[TW-1] ? (HALF_T - r_t) : (r_t + HALF_T);
    assign w_m     = RW'(i_cfg.order);
    assign w_two_m = RW'({i_cfg.order, 1'b0});
    assign n_q2    = r_neg ? (w_two_m - r_r) : (w_two_m + r_r);
    assign w_g     = gray_to_bin(r_k);

    always_comb begin
        priority if (r_q2 >= w_two_m) begin
            w_k_full = r_q2 - w_two_m;
        end else if (r_q2 >= w_m) begin
            w_k_full = r_q2 - w_m;
        end else begin
            w_k_full = r_q2;
        end
    end

    always_comb begin
        priority if (i_cfg.binary_order) begin
            n_sym = r_k;
        end else if (w_g >= i_cfg.order) begin
            n_sym = w_g - i_cfg.order;
        end else begin
            n_sym = w_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= n_a;
            r_d   <= n_d;
            r_t   <= n_t;
            r_r   <= w_mag[TW-1:PHASE_BITS];
            r_neg <= r_t[TW-1];
            r_q2  <= n_q2;
            r_k   <= w_k_full[C_ORDER_W-1:0];
            r_sym <= n_sym[C_SYMBOL_W-1:0];
        end
    end

    assign o_vld    = r_vld[STAGES-1];
    assign o_symbol = r_sym;

endmodule

### rtl/psk_hard_demapper_core.sv
// ----------------------------------------------------------------------------
// PSK hard demapper core
// Accepts one transaction per clock cycle unless stalled; each symbol passes
// through the input stage, which loads when its sample is accepted, then
// thirty CORDIC cells, seven slicer stages and the output register.
// The input stalls only while the output skid register is occupied.
// Synchronous active-low reset empties the pipeline and sets order 4, phase
// offset 0 and Gray mapping.
// ----------------------------------------------------------------------------
module psk_hard_demapper_core #(
    parameter int SAMPLE_BITS = psk_hd_pkg::C_SAMPLE_BITS,
    parameter int PHASE_BITS  = psk_hd_pkg::C_PHASE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [psk_hd_pkg::C_CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [psk_hd_pkg::C_CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]          i_in_phase,
    input  logic signed [SAMPLE_BITS-1:0]          i_quadrature,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [psk_hd_pkg::C_SYMBOL_W-1:0]      o_symbol
);
    import psk_hd_pkg::*;

    localparam int XY_W  = SAMPLE_BITS + C_PRESCALE + 2;
    localparam int EXT_W = SAMPLE_BITS + 2;

    t_cfg                        r_cfg;
    t_cfg                        n_cfg;
    logic [C_ORDER_W-1:0]        w_cfg_order;

    logic                        w_en;
    logic                        w_neg;
    logic signed [EXT_W-1:0]     w_i_ext;
    logic signed [EXT_W-1:0]     w_q_ext;
    logic signed [EXT_W-1:0]     w_x0;
    logic signed [EXT_W-1:0]     w_y0;
    t_ctl                        r_ctl0;
    logic signed [XY_W-1:0]      r_x0;
    logic signed [XY_W-1:0]      r_y0;
    logic signed [C_ANGLE_W-1:0] r_z0;
    logic signed [C_ANGLE_W-1:0] n_z0;

    t_ctl                        w_ctl [C_CORDIC_STEPS+1];
    logic signed [XY_W-1:0]      w_x   [C_CORDIC_STEPS+1];
    logic signed [XY_W-1:0]      w_y   [C_CORDIC_STEPS+1];
    logic signed [C_ANGLE_W-1:0] w_z   [C_CORDIC_STEPS+1];

    logic                        w_pipe_vld;
    logic [C_SYMBOL_W-1:0]       w_pipe_sym;
    logic                        w_out_ready;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [C_SYMBOL_W-1:0]       r_out_sym;
    logic [C_SYMBOL_W-1:0]       n_out_sym;
    logic                        r_skid_valid;
    logic                        n_skid_valid;
    logic [C_SYMBOL_W-1:0]       r_skid_sym;
    logic [C_SYMBOL_W-1:0]       n_skid_sym;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_order = i_cfg_data[C_ORDER_W-1:0];

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ORDER: begin
                    if (int'(w_cfg_order) > C_MAX_ORDER) begin
                        n_cfg.order = C_ORDER_W'(C_MAX_ORDER);
                    end else if (int'(w_cfg_order) >= C_MIN_ORDER) begin
                        n_cfg.order = w_cfg_order;
                    end
                end
                CFG_PHASE_OFFSET: begin
                    n_cfg.phase_offset = i_cfg_data[C_OFFSET_W-1:0];
                end
                CFG_BINARY_ORDER: begin
                    n_cfg.binary_order = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{order: C_ORDER_W'(C_ORDER_RESET), phase_offset: '0, binary_order: 1'b0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign w_en       = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    assign w_neg   = i_in_phase[SAMPLE_BITS-1];
    assign w_i_ext = EXT_W'(i_in_phase);
    assign w_q_ext = EXT_W'(i_quadrature);
    assign w_x0    = w_neg ? -w_i_ext : w_i_ext;
    assign w_y0    = w_neg ? -w_q_ext : w_q_ext;

    always_comb begin
        if (!w_neg) begin
            n_z0 = '0;
        end else if (i_quadrature[SAMPLE_BITS-1]) begin
            n_z0 = -C_HALF_TURN;
        end else begin
            n_z0 = C_HALF_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (w_en) begin
            r_ctl0.vld  <= i_in_valid;
            r_ctl0.zero <= (i_in_phase == '0) && (i_quadrature == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0 <= {w_x0, C_PRESCALE'(0)};
            r_y0 <= {w_y0, C_PRESCALE'(0)};
            r_z0 <= n_z0;
        end
    end

    assign w_ctl[0] = r_ctl0;
    assign w_x[0]   = r_x0;
    assign w_y[0]   = r_y0;
    assign w_z[0]   = r_z0;

    generate
        for (genvar g = 0; g < C_CORDIC_STEPS; g++) begin : g_cell
            psk_hd_cordic_cell #(
                .STEP (g),
                .XY_W (XY_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_ctl   (w_ctl[g]),
                .i_x     (w_x[g]),
                .i_y     (w_y[g]),
                .i_z     (w_z[g]),
                .o_ctl   (w_ctl[g+1]),
                .o_x     (w_x[g+1]),
                .o_y     (w_y[g+1]),
                .o_z     (w_z[g+1])
            );
        end
    endgenerate

    psk_hd_slicer #(
        .PHASE_BITS (PHASE_BITS)
    ) u_slicer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (w_ctl[C_CORDIC_STEPS]),
        .i_z      (w_z[C_CORDIC_STEPS]),
        .i_cfg    (r_cfg),
        .o_vld    (w_pipe_vld),
        .o_symbol (w_pipe_sym)
    );

    assign w_out_ready = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_sym    = r_out_sym;
        n_skid_valid = r_skid_valid;
        n_skid_sym   = r_skid_sym;
        if (w_out_ready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_sym    = r_skid_sym;
                n_skid_valid = 1'b0;
            end else if (w_en && w_pipe_vld) begin
                n_out_valid = 1'b1;
                n_out_sym   = w_pipe_sym;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_en && w_pipe_vld) begin
            n_skid_valid = 1'b1;
            n_skid_sym   = w_pipe_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sym  <= n_out_sym;
        r_skid_sym <= n_skid_sym;
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_out_sym;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid register holds a symbol while the output register is empty.");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("Skid register filled while the output was free.");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_skid_valid) && $past(i_rst_n)) |-> $past(!i_out_stall))
        else $error("Skid register emptied without an output transaction.");

    a_skid_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> r_out_valid)
        else $error("Skid symbol lost when the output was taken.");
`endif

endmodule
